// ===== rtl/core/bgn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgn_pkg
// Shared types and constants of the branch guard nop scanner.
// ----------------------------------------------------------------------------
package bgn_pkg;

  localparam int unsigned INSN_BITS  = 32;
  localparam int unsigned ADDR_BITS  = 48;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned DIST_BITS  = 5;

  // opcode recognition
  localparam logic [31:0] BCOND_MASK  = 32'hff000010;
  localparam logic [31:0] BCOND_MATCH = 32'h54000000;
  localparam logic [31:0] CBZ_MASK    = 32'h7e000000;
  localparam logic [31:0] CBZ_MATCH   = 32'h34000000;
  localparam logic [31:0] BL_MASK     = 32'hfc000000;
  localparam logic [31:0] BL_MATCH    = 32'h94000000;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [INSN_BITS-1:0] instruction;
    logic [ADDR_BITS-1:0] word_address;
    logic                 last_word;
  } in_t;

  typedef struct packed {
    logic                  call_hits_target;
    logic                  patch_found;
    logic [DIST_BITS-1:0]  patch_distance;
    logic [ADDR_BITS-1:0]  patch_address;
    logic [COUNT_BITS-1:0] call_count;
    logic [COUNT_BITS-1:0] patched_count;
    logic [COUNT_BITS-1:0] missed_count;
  } out_t;

  typedef struct packed {
    logic                 is_call;
    logic [ADDR_BITS-1:0] call_target;
    logic                 is_branch;
    logic [ADDR_BITS-1:0] branch_target;
  } decode_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bgn_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgn_decode
// Recognizes BL, B.cond and CBZ/CBNZ and forms their absolute targets.
// ----------------------------------------------------------------------------
module bgn_decode (
  input  logic [bgn_pkg::INSN_BITS-1:0] instruction,
  input  logic [bgn_pkg::ADDR_BITS-1:0] word_address,
  output bgn_pkg::decode_t              decoded
);

  logic [bgn_pkg::ADDR_BITS-1:0] call_offset;
  logic [bgn_pkg::ADDR_BITS-1:0] branch_offset;
  logic                          is_bcond;
  logic                          is_cbz;

  // sign-extended word offsets scaled to bytes
  assign call_offset = {{(bgn_pkg::ADDR_BITS-28){instruction[25]}}, instruction[25:0], 2'b00};
  assign branch_offset = {{(bgn_pkg::ADDR_BITS-21){instruction[23]}}, instruction[23:5], 2'b00};

  assign is_bcond = (instruction & bgn_pkg::BCOND_MASK) == bgn_pkg::BCOND_MATCH;
  assign is_cbz   = (instruction & bgn_pkg::CBZ_MASK) == bgn_pkg::CBZ_MATCH;

  assign decoded.is_call       = (instruction & bgn_pkg::BL_MASK) == bgn_pkg::BL_MATCH;
  assign decoded.call_target   = word_address + call_offset;
  assign decoded.is_branch     = is_bcond || is_cbz;
  assign decoded.branch_target = word_address + branch_offset;

endmodule

// ===== rtl/core/bgn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgn_cell
// One window slot: holds a recent branch target and hands it to the next slot.
// ----------------------------------------------------------------------------
module bgn_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  bgn_pkg::cell_ctrl_t           ctrl,
  input  logic                          kill,
  input  logic [bgn_pkg::ADDR_BITS-1:0] probe,
  input  logic [bgn_pkg::ADDR_BITS-1:0] prev_target,
  input  logic                          prev_valid,
  output logic [bgn_pkg::ADDR_BITS-1:0] pass_target,
  output logic                          pass_valid,
  output logic                          match
);

  logic [bgn_pkg::ADDR_BITS-1:0] target;
  logic                          valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= ctrl.clear ? 1'b0 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      target <= prev_target;
    end
  end

  assign match       = valid && (target == probe);
  // a patched branch is a nop and moves on as invalid
  assign pass_valid  = valid && !kill;
  assign pass_target = target;

endmodule

// ===== rtl/core/branch_guard_nop_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_guard_nop_scanner_unit
// Finds the conditional branch that guards each call to a failure routine.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one instruction word with its
// address and a last-word flag. Output channel out_valid/out_stall returns
// exactly one result per word: call hit, patch location and scan counters.
// The user must write the register fail_target through cfg_write_en and
// cfg_write_data only while the block is idle; the block does not check.
// A word accepted at a clock edge has its result in the output register
// after that edge. One word is accepted every cycle while the output is not
// stalled; the look-back over the window is a row of WINDOW_DEPTH cells
// that shift on each accepted word and compare against the call address in
// parallel. A stalled receiver holds the output register and stalls the
// input side until the result is taken.
// Reset clears the window, the counters, fail_target and the output valid.
// A word flagged last clears the window and counters after its result.
// ----------------------------------------------------------------------------
module branch_guard_nop_scanner_unit #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bgn_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bgn_pkg::out_t                 out_data,
  input  logic                          cfg_write_en,
  input  logic [bgn_pkg::ADDR_BITS-1:0] cfg_write_data
);

  localparam int unsigned IDX_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned DIST_W    = $clog2(WINDOW_DEPTH + 1);

  logic [bgn_pkg::ADDR_BITS-1:0]  fail_target;
  logic [bgn_pkg::COUNT_BITS-1:0] calls_seen;
  logic [bgn_pkg::COUNT_BITS-1:0] patches_made;
  logic [bgn_pkg::COUNT_BITS-1:0] patches_missed;
  logic [bgn_pkg::COUNT_BITS-1:0] calls_seen_next;
  logic [bgn_pkg::COUNT_BITS-1:0] patches_made_next;
  logic [bgn_pkg::COUNT_BITS-1:0] patches_missed_next;

  logic                           accept;
  bgn_pkg::decode_t               decoded;
  bgn_pkg::cell_ctrl_t            cell_ctrl;
  logic                           hit;
  logic                           found;
  logic                           any_match;
  logic [IDX_BITS-1:0]            sel_idx;
  logic [DIST_W-1:0]              patch_dist;
  logic [bgn_pkg::ADDR_BITS-1:0]  dist_ext;
  logic [bgn_pkg::ADDR_BITS-1:0]  patch_address;
  logic [WINDOW_DEPTH-1:0]        match;
  logic [WINDOW_DEPTH-1:0]        kill;
  logic [bgn_pkg::ADDR_BITS-1:0]  target_chain [WINDOW_DEPTH+1];
  logic [WINDOW_DEPTH:0]          valid_chain;
  bgn_pkg::out_t                  result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  bgn_decode u_decode (
    .instruction  (in_data.instruction),
    .word_address (in_data.word_address),
    .decoded      (decoded)
  );

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = in_data.last_word;

  // the current word enters at the head of the chain
  assign target_chain[0] = decoded.is_branch ? decoded.branch_target : '0;
  assign valid_chain[0]  = decoded.is_branch;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    bgn_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .kill        (kill[i]),
      .probe       (in_data.word_address),
      .prev_target (target_chain[i]),
      .prev_valid  (valid_chain[i]),
      .pass_target (target_chain[i+1]),
      .pass_valid  (valid_chain[i+1]),
      .match       (match[i])
    );
  end

  assign hit = decoded.is_call && (decoded.call_target == fail_target);

  // nearest matching slot wins
  always_comb begin
    any_match = 1'b0;
    sel_idx   = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (match[i] && !any_match) begin
        any_match = 1'b1;
        sel_idx   = IDX_BITS'(i);
      end
    end
  end

  assign found = hit && any_match;

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      kill[i] = found && (sel_idx == IDX_BITS'(i));
    end
  end

  assign patch_dist    = found ? (DIST_W'(sel_idx) + DIST_W'(1)) : '0;
  assign dist_ext      = bgn_pkg::ADDR_BITS'(patch_dist);
  assign patch_address = found ? (in_data.word_address - {dist_ext[bgn_pkg::ADDR_BITS-3:0], 2'b00})
                               : '0;

  always_comb begin
    calls_seen_next     = calls_seen;
    patches_made_next   = patches_made;
    patches_missed_next = patches_missed;
    if (decoded.is_call && calls_seen != bgn_pkg::COUNT_MAX) begin
      calls_seen_next = calls_seen + bgn_pkg::COUNT_BITS'(1);
    end
    if (found && patches_made != bgn_pkg::COUNT_MAX) begin
      patches_made_next = patches_made + bgn_pkg::COUNT_BITS'(1);
    end
    if (hit && !found && patches_missed != bgn_pkg::COUNT_MAX) begin
      patches_missed_next = patches_missed + bgn_pkg::COUNT_BITS'(1);
    end
  end

  always_comb begin
    result.call_hits_target = hit;
    result.patch_found      = found;
    result.patch_distance   = dist_ext[bgn_pkg::DIST_BITS-1:0];
    result.patch_address    = patch_address;
    result.call_count       = calls_seen_next;
    result.patched_count    = patches_made_next;
    result.missed_count     = patches_missed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_target <= '0;
    end else if (cfg_write_en) begin
      fail_target <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calls_seen     <= '0;
      patches_made   <= '0;
      patches_missed <= '0;
    end else if (accept) begin
      if (in_data.last_word) begin
        calls_seen     <= '0;
        patches_made   <= '0;
        patches_missed <= '0;
      end else begin
        calls_seen     <= calls_seen_next;
        patches_made   <= patches_made_next;
        patches_missed <= patches_missed_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ===== tb/branch_guard_nop_scanner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_guard_nop_scanner_unit_tb
// Feeds instruction scans through the guard scanner under random valid and
// stall gaps, and compares every result with a transaction-level model of
// the call decode, the look-back search and the scan counters.
// ----------------------------------------------------------------------------
module branch_guard_nop_scanner_unit_tb;

  localparam int WINDOW_SPAN  = 16;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_WORDS = 1360;
  localparam int PHASES       = 8;
  localparam logic [bgn_pkg::ADDR_BITS-1:0] ADDR_TOP = '1;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  bgn_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_stall;
  bgn_pkg::out_t                 out_data;
  logic                          cfg_write_en;
  logic [bgn_pkg::ADDR_BITS-1:0] cfg_write_data;

  class patch_tracker;
    logic [bgn_pkg::ADDR_BITS-1:0]  fail_target;
    logic [bgn_pkg::ADDR_BITS-1:0]  guard_dest [WINDOW_SPAN];
    bit                             guard_live [WINDOW_SPAN];
    int                             window_fill;
    logic [bgn_pkg::COUNT_BITS-1:0] calls_seen;
    logic [bgn_pkg::COUNT_BITS-1:0] patches_made;
    logic [bgn_pkg::COUNT_BITS-1:0] patches_missed;
    bgn_pkg::out_t                  expected_results [$];
    int                             failures;

    function new();
      fail_target = '0;
      failures = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (guard_dest[k]) begin
        guard_dest[k] = '0;
        guard_live[k] = 1'b0;
      end
      window_fill = 0;
      calls_seen = '0;
      patches_made = '0;
      patches_missed = '0;
    endfunction

    function logic [bgn_pkg::COUNT_BITS-1:0] bump(logic [bgn_pkg::COUNT_BITS-1:0] c);
      return (c == bgn_pkg::COUNT_MAX) ? c : c + bgn_pkg::COUNT_BITS'(1);
    endfunction

    function void record_word(bgn_pkg::in_t w);
      bgn_pkg::out_t                 res;
      logic [bgn_pkg::ADDR_BITS-1:0] pc;
      logic [bgn_pkg::ADDR_BITS-1:0] dest;
      logic                          is_guard;
      int                            d;
      res = '0;
      pc = w.word_address;
      if ((w.instruction & bgn_pkg::BL_MASK) == bgn_pkg::BL_MATCH) begin
        dest = pc + {{20{w.instruction[25]}}, w.instruction[25:0], 2'b00};
        calls_seen = bump(calls_seen);
        if (dest == fail_target) begin
          res.call_hits_target = 1'b1;
          // nearest unpatched guard aimed at this call wins
          for (d = 1; d <= window_fill; d++) begin
            if (!res.patch_found && guard_live[d-1] && guard_dest[d-1] == pc) begin
              guard_live[d-1] = 1'b0;
              res.patch_found = 1'b1;
              res.patch_distance = d[bgn_pkg::DIST_BITS-1:0];
              res.patch_address = pc - (bgn_pkg::ADDR_BITS'(d) << 2);
            end
          end
          if (res.patch_found) begin
            patches_made = bump(patches_made);
          end else begin
            patches_missed = bump(patches_missed);
          end
        end
      end
      is_guard = ((w.instruction & bgn_pkg::BCOND_MASK) == bgn_pkg::BCOND_MATCH) ||
                 ((w.instruction & bgn_pkg::CBZ_MASK) == bgn_pkg::CBZ_MATCH);
      for (d = WINDOW_SPAN - 1; d > 0; d--) begin
        guard_dest[d] = guard_dest[d-1];
        guard_live[d] = guard_live[d-1];
      end
      guard_dest[0] = is_guard ?
          pc + {{27{w.instruction[23]}}, w.instruction[23:5], 2'b00} : '0;
      guard_live[0] = is_guard;
      if (window_fill < WINDOW_SPAN) window_fill++;
      res.call_count = calls_seen;
      res.patched_count = patches_made;
      res.missed_count = patches_missed;
      expected_results.push_back(res);
      if (w.last_word) clear_scan();
    endfunction

    function void compare_field(string name, logic [bgn_pkg::ADDR_BITS-1:0] want,
                                logic [bgn_pkg::ADDR_BITS-1:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(bgn_pkg::out_t got);
      bgn_pkg::out_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with none pending: expected nothing, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        compare_field("call_hits_target", want.call_hits_target, got.call_hits_target);
        compare_field("patch_found", want.patch_found, got.patch_found);
        compare_field("patch_distance", want.patch_distance, got.patch_distance);
        compare_field("patch_address", want.patch_address, got.patch_address);
        compare_field("call_count", want.call_count, got.call_count);
        compare_field("patched_count", want.patched_count, got.patched_count);
        compare_field("missed_count", want.missed_count, got.missed_count);
      end
    endfunction
  endclass

  patch_tracker board = new();
  bit           quiet;
  int           words_sent;

  branch_guard_nop_scanner_unit #(
    .WINDOW_DEPTH(WINDOW_SPAN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [bgn_pkg::ADDR_BITS-1:0] rand_addr();
    return bgn_pkg::ADDR_BITS'({$urandom, $urandom});
  endfunction

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 24);
    if (r < 95) return $urandom_range(25, 60);
    return $urandom_range(61, 120);
  endfunction

  function automatic logic [31:0] bl_word(input logic [bgn_pkg::ADDR_BITS-1:0] pc,
                                         input logic [bgn_pkg::ADDR_BITS-1:0] dest);
    logic [bgn_pkg::ADDR_BITS-1:0] delta;
    delta = dest - pc;
    return bgn_pkg::BL_MATCH | {6'b0, delta[27:2]};
  endfunction

  function automatic logic [31:0] bcond_word(input logic [bgn_pkg::ADDR_BITS-1:0] pc,
                                            input logic [bgn_pkg::ADDR_BITS-1:0] dest,
                                            input logic [3:0] cond);
    logic [bgn_pkg::ADDR_BITS-1:0] delta;
    delta = dest - pc;
    return bgn_pkg::BCOND_MATCH | {8'h00, delta[20:2], 1'b0, cond};
  endfunction

  function automatic logic [31:0] cb_word(input logic [bgn_pkg::ADDR_BITS-1:0] pc,
                                         input logic [bgn_pkg::ADDR_BITS-1:0] dest,
                                         input logic sf, input logic op,
                                         input logic [4:0] rt);
    logic [bgn_pkg::ADDR_BITS-1:0] delta;
    delta = dest - pc;
    return bgn_pkg::CBZ_MATCH | {sf, 6'b0, op, delta[20:2], rt};
  endfunction

  function automatic logic [31:0] guard_word(input logic [bgn_pkg::ADDR_BITS-1:0] pc,
                                            input logic [bgn_pkg::ADDR_BITS-1:0] dest);
    if ($urandom_range(0, 1) == 1)
      return bcond_word(pc, dest, 4'($urandom_range(0, 15)));
    return cb_word(pc, dest, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   5'($urandom_range(0, 31)));
  endfunction

  task automatic send_word(input logic [31:0] insn,
                           input logic [bgn_pkg::ADDR_BITS-1:0] addr,
                           input logic last);
    bgn_pkg::in_t w;
    int           gap;
    w.instruction = insn;
    w.word_address = addr;
    w.last_word = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.record_word(w);
    words_sent++;
  endtask

  task automatic set_fail_target(input logic [bgn_pkg::ADDR_BITS-1:0] value);
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    board.fail_target = value;
  endtask

  // one scan: guards planted ahead of calls to the failure routine, plus noise
  task automatic run_scan(input int len);
    logic [bgn_pkg::ADDR_BITS-1:0] pc;
    logic [31:0]                   insn;
    bit                            call_due [];
    int                            i;
    int                            r;
    int                            d;
    call_due = new[len];
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) begin
      pc = rand_addr();
    end else begin
      pc = board.fail_target - 48'h40_0000 +
           (bgn_pkg::ADDR_BITS'($urandom_range(0, 32'h1f_ffff)) << 2);
    end
    for (i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (call_due[i] && r < 90) begin
        insn = bl_word(pc, board.fail_target);
      end else if (r < 30) begin
        d = $urandom_range(1, 20);
        insn = guard_word(pc, pc + (bgn_pkg::ADDR_BITS'(d) << 2));
        if (i + d < len) call_due[i + d] = 1'b1;
      end else if (r < 40) begin
        insn = bl_word(pc, board.fail_target);
      end else if (r < 46) begin
        insn = bgn_pkg::BL_MATCH | ($urandom & ~bgn_pkg::BL_MASK);
      end else if (r < 50) begin
        insn = bgn_pkg::BCOND_MATCH | ($urandom & ~bgn_pkg::BCOND_MASK);
      end else if (r < 54) begin
        insn = bgn_pkg::CBZ_MATCH | ($urandom & ~bgn_pkg::CBZ_MASK);
      end else begin
        insn = $urandom;
      end
      // the same call twice at one address takes the next guard in line
      if (insn == bl_word(pc, board.fail_target) && $urandom_range(0, 7) == 0)
        send_word(insn, pc, 1'b0);
      send_word(insn, pc, i == len - 1);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        pc = rand_addr();
      end else if (r >= 5) begin
        pc = pc + 48'd4;
      end
    end
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(out_data);
      if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("branch_guard_nop_scanner_unit_tb failed");
    $finish;
  end

  initial begin : stimulus
    int                            p;
    int                            phase_start;
    logic [bgn_pkg::ADDR_BITS-1:0] target;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    quiet = 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fail_target still at its reset value of zero
    send_word(32'h0000_0000, 48'h0, 1'b0);
    send_word(32'hffff_ffff, ADDR_TOP, 1'b0);
    // guard whose target wraps past the top of the address space
    send_word(bcond_word(ADDR_TOP - 3, 48'h0, 4'hf), ADDR_TOP - 3, 1'b0);
    // bit 4 set: not a conditional branch
    send_word(bgn_pkg::BCOND_MATCH | 32'h10, 48'h10, 1'b0);
    send_word(cb_word(48'h20, 48'h0, 1'b0, 1'b0, 5'd0), 48'h20, 1'b0);
    send_word(bl_word(48'h0, 48'h0), 48'h0, 1'b0);
    send_word(bl_word(48'h0, 48'h0), 48'h0, 1'b0);
    send_word(bl_word(48'h0, 48'h0), 48'h0, 1'b0);
    send_word(bl_word(48'h4, 48'h8), 48'h4, 1'b0);
    // a guard in one scan must not serve a call in the next
    send_word(cb_word(48'h3000, 48'h3004, 1'b1, 1'b1, 5'd31), 48'h3000, 1'b1);
    send_word(bl_word(48'h3004, 48'h0), 48'h3004, 1'b0);
    // offset extremes of both branch forms and of the call
    send_word(bcond_word(48'h7f0_0004, 48'h800_0000, 4'h1), 48'h7f0_0004, 1'b0);
    send_word(cb_word(48'h810_0000, 48'h800_0000, 1'b0, 1'b1, 5'd7), 48'h810_0000, 1'b0);
    send_word(bl_word(48'h800_0000, 48'h0), 48'h800_0000, 1'b0);
    send_word(bl_word(ADDR_TOP - 48'h7ff_fffb, 48'h0), ADDR_TOP - 48'h7ff_fffb, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: target = ADDR_TOP;
        2: target = '0;
        4: target = {1'b1, 47'h0};
        default: target = rand_addr();
      endcase
      set_fail_target(target);
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / PHASES) run_scan(pick_len());
    end

    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("branch_guard_nop_scanner_unit_tb passed");
    end else begin
      $display("branch_guard_nop_scanner_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bgn_pkg.sv
rtl/core/bgn_decode.sv
rtl/core/bgn_cell.sv
rtl/core/branch_guard_nop_scanner_unit.sv
tb/branch_guard_nop_scanner_unit_tb.sv
